// ----- rtl/core/sbs_pkg.sv -----
package sbs_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 14;
  localparam int SLOT_W      = 13;
  localparam int KEY_W       = 64;
  localparam int IDX_W       = 32;

  localparam logic [IDX_W-1:0] NOT_FOUND_INDEX = '1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  index;
  } tbl_wr_t;

endpackage

// ----- rtl/core/sbs_if.sv -----
interface sbs_req_if;
  import sbs_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [SLOT_W-1:0] entry_slot;
  logic [KEY_W-1:0]  key_hash;
  logic [IDX_W-1:0]  entry_image_index;

  modport source (
    output valid, command, entry_slot, key_hash, entry_image_index,
    input  ready
  );
  modport sink (
    input  valid, command, entry_slot, key_hash, entry_image_index,
    output ready
  );
endinterface

interface sbs_rsp_if;
  import sbs_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] image_index;

  modport source (
    output valid, found, image_index,
    input  ready
  );
  modport sink (
    input  valid, found, image_index,
    output ready
  );
endinterface

// ----- rtl/core/sbs_table.sv -----
module sbs_table (
  input  logic                         clk,
  input  sbs_pkg::tbl_wr_t             wr,
  input  logic                         rd_en,
  input  logic [sbs_pkg::ADDR_W-1:0]   rd_addr,
  output logic [sbs_pkg::KEY_W-1:0]    rd_key,
  output logic [sbs_pkg::IDX_W-1:0]    rd_index
);
  import sbs_pkg::*;

  // key and image index share one word per entry
  logic [KEY_W+IDX_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W+IDX_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.key, wr.index};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_key   = rd_word[KEY_W+IDX_W-1:IDX_W];
  assign rd_index = rd_word[IDX_W-1:0];

endmodule

// ----- rtl/core/sorted_table_binary_search_core.sv -----
// Binary search over a table of 64-bit keys, each stored with a 32-bit image index in one
// single-port-read, single-port-write memory with a registered read. A write beat (command 0)
// stores one entry and leaves the core in idle, ready for the next beat. A lookup beat
// (command 1) bisects the first entry_count entries (saturated to the table depth), which the
// user keeps in ascending order. Each probe reads the memory in ST_READ and then compares
// in ST_CMP; a lookup makes at most 14 probes for a full table of 8192 entries, and an
// empty table answers without a probe. The result register lets a new beat be taken
// while the previous answer waits on rsp.
module sorted_table_binary_search_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [sbs_pkg::COUNT_W-1:0]  cfg_data,
  sbs_req_if.sink                      req,
  sbs_rsp_if.source                    rsp
);
  import sbs_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [COUNT_W-1:0]  entry_count;
  logic [KEY_W-1:0]    key_q;
  logic [ADDR_W-1:0]   low;
  logic [ADDR_W-1:0]   high;
  logic [ADDR_W-1:0]   mid;
  logic [ADDR_W-1:0]   high_init;
  logic                count_zero;
  logic                res_found;
  logic [IDX_W-1:0]    res_index;
  logic                out_valid;
  logic                out_found;
  logic [IDX_W-1:0]    out_index;
  logic                out_free;
  logic                accept;
  logic                hit;
  logic                key_lt;
  logic                range_empty;
  logic                rd_en;
  logic [KEY_W-1:0]    rd_key;
  logic [IDX_W-1:0]    rd_index;
  tbl_wr_t             tbl_wr;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign mid      = low + ((high - low) >> 1);

  assign hit         = (rd_key == key_q);
  assign key_lt      = (rd_key < key_q);
  // no entries left on the side the compare points to
  assign range_empty = key_lt ? (mid == high) : (mid == low);

  assign count_zero = (entry_count == '0);
  always_comb begin
    if (32'(entry_count) > TABLE_DEPTH) begin
      high_init = ADDR_W'(TABLE_DEPTH - 1);
    end else begin
      high_init = ADDR_W'(entry_count - 1'b1);
    end
  end

  sbs_table u_table (
    .clk      (clk),
    .wr       (tbl_wr),
    .rd_en    (rd_en),
    .rd_addr  (mid),
    .rd_key   (rd_key),
    .rd_index (rd_index)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req.command == CMD_LOOKUP) begin
          state_next = count_zero ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_next = ST_CMP;
      ST_CMP: begin
        state_next = (hit || range_empty) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready    = 1'b0;
    rd_en        = 1'b0;
    tbl_wr.en    = 1'b0;
    tbl_wr.addr  = ADDR_W'(req.entry_slot);
    tbl_wr.key   = req.key_hash;
    tbl_wr.index = req.entry_image_index;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        tbl_wr.en = accept && req.command == CMD_WRITE
                    && 32'(req.entry_slot) < TABLE_DEPTH;
      end
      ST_READ: rd_en = 1'b1;
      ST_CMP:  rd_en = 1'b0;
      ST_DONE: rd_en = 1'b0;
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        entry_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && req.command == CMD_LOOKUP) begin
          key_q     <= req.key_hash;
          low       <= '0;
          high      <= high_init;
          res_found <= 1'b0;
          res_index <= NOT_FOUND_INDEX;
        end
      end
      ST_CMP: begin
        if (hit) begin
          res_found <= 1'b1;
          res_index <= rd_index;
        end else if (key_lt) begin
          low <= mid + 1'b1;
        end else begin
          high <= mid - 1'b1;
        end
      end
      ST_READ: ;
      ST_DONE: ;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_found <= res_found;
      out_index <= res_index;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.image_index = out_index;

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (low <= high))
    else $error("probe issued with an empty range");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> (state == ST_IDLE))
    else $error("table write outside idle");

  a_hit_ends_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && hit) |=> (state == ST_DONE && res_found))
    else $error("match did not end the search");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_index == NOT_FOUND_INDEX))
    else $error("miss reported with a real index");

  a_search_read_only: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_CMP) |-> !req.ready)
    else $error("beat taken during a search");

endmodule

// ----- tb/sv/sorted_table_binary_search_core_test.sv -----
module sorted_table_binary_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sbs_pkg::*;

  class search_scoreboard;
    typedef struct {
      logic             found;
      logic [IDX_W-1:0] image_index;
    } answer_t;

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [IDX_W-1:0] index_mem [TABLE_DEPTH];
    int unsigned      entry_count;
    answer_t          answer_q [$];
    int               errors;

    function new();
      entry_count = 0;
      errors = 0;
    endfunction

    function void set_count(int unsigned c);
      entry_count = c;
    endfunction

    // bisection over the first entry_count entries, first matching midpoint wins
    function answer_t search_table(logic [KEY_W-1:0] key);
      answer_t a;
      int lo;
      int hi;
      int mid;
      a.found = 1'b0;
      a.image_index = NOT_FOUND_INDEX;
      lo = 0;
      hi = ((entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count) - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (key_mem[mid] == key) begin
          a.found = 1'b1;
          a.image_index = index_mem[mid];
          return a;
        end
        if (key_mem[mid] < key) lo = mid + 1;
        else hi = mid - 1;
      end
      return a;
    endfunction

    function void note_beat(logic cmd, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key,
                            logic [IDX_W-1:0] img);
      if (cmd == CMD_WRITE) begin
        if (slot < TABLE_DEPTH) begin
          key_mem[slot] = key;
          index_mem[slot] = img;
        end
      end else begin
        answer_q.push_back(search_table(key));
      end
    endfunction

    function void check_answer(logic found, logic [IDX_W-1:0] image_index);
      answer_t exp;
      if (answer_q.size() == 0) begin
        $error("result beat with no lookup pending: found %0b image_index %h",
               found, image_index);
        errors++;
        return;
      end
      exp = answer_q.pop_front();
      if (found !== exp.found) begin
        $error("found: expected %0b, actual %0b", exp.found, found);
        errors++;
      end
      if (image_index !== exp.image_index) begin
        $error("image_index: expected %h, actual %h", exp.image_index, image_index);
        errors++;
      end
    endfunction

    function int pending();
      return answer_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [COUNT_W-1:0] cfg_data;

  sbs_req_if req_if ();
  sbs_rsp_if rsp_if ();

  sorted_table_binary_search_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  search_scoreboard sb;
  int unsigned      gap_max = 8;
  int unsigned      beats = 0;
  bit               rx_stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // valid stays high after a beat; anything that waits must drop it first
  task automatic send_beat(logic cmd, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key,
                           logic [IDX_W-1:0] img);
    int unsigned gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid             <= 1'b1;
    req_if.command           <= cmd;
    req_if.entry_slot        <= slot;
    req_if.key_hash          <= key;
    req_if.entry_image_index <= img;
    do @(posedge clk); while (!req_if.ready);
    sb.note_beat(cmd, slot, key, img);
    beats++;
  endtask

  task automatic lookup(logic [KEY_W-1:0] key);
    send_beat(CMD_LOOKUP, SLOT_W'($urandom), key, $urandom);
  endtask

  task automatic drain_answers();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic set_entry_count(int unsigned c);
    cfg_write <= 1'b1;
    cfg_data  <= COUNT_W'(c);
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_count(c);
  endtask

  // hits, near misses, random keys and the key extremes
  function automatic logic [KEY_W-1:0] pick_probe_key(int unsigned eff);
    logic [KEY_W-1:0] k;
    int unsigned      r;
    r = $urandom_range(0, 9);
    k = rand_key();
    if (eff != 0 && r <= 6) k = sb.key_mem[$urandom_range(0, eff - 1)];
    case (r)
      5: k = k + 1;
      6: k = k - 1;
      8: k = '0;
      9: k = '1;
      default: ;
    endcase
    return k;
  endfunction

  initial begin : stimulus
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] nk;
    logic [KEY_W-1:0] inc;
    logic [IDX_W-1:0] img;
    int unsigned      count;
    int unsigned      eff;
    int unsigned      r;
    bit               mixed;
    sb = new();
    rst                      <= 1'b1;
    cfg_write                <= 1'b0;
    cfg_data                 <= '0;
    req_if.valid             <= 1'b0;
    req_if.command           <= CMD_WRITE;
    req_if.entry_slot        <= '0;
    req_if.key_hash          <= '0;
    req_if.entry_image_index <= '0;
    rsp_if.ready             <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset, ignored fields at their extremes
    send_beat(CMD_LOOKUP, '1, '0, '1);
    send_beat(CMD_LOOKUP, '0, '1, '0);
    lookup(rand_key());
    k = rand_key();
    send_beat(CMD_WRITE, '0, k, '1);
    send_beat(CMD_WRITE, '1, rand_key(), '0);
    drain_answers();
    set_entry_count(1);
    lookup(k);
    lookup(k + 1);
    lookup('0);
    // index 0 on a hit must not look like a miss
    send_beat(CMD_WRITE, '0, '0, '0);
    send_beat(CMD_WRITE, SLOT_W'(1), '1, $urandom);
    lookup('0);
    drain_answers();
    set_entry_count(2);
    lookup('1);
    lookup('0);
    lookup(64'd5);
    lookup('1 - 1);

    // full table, strictly ascending with wide gaps, loaded back to back
    drain_answers();
    set_entry_count(TABLE_DEPTH);
    gap_max = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      nk = rand_key();
      nk[KEY_W-1:50] = '0;
      k = (64'(i) << 51) | nk;
      img = $urandom;
      if (i == 0) k = '0;
      if (i == TABLE_DEPTH - 1) begin
        k = '1;
        img = '1;
      end
      send_beat(CMD_WRITE, SLOT_W'(i), k, img);
    end
    gap_max = 8;
    lookup('1);
    lookup('0);
    repeat (40) lookup(pick_probe_key(TABLE_DEPTH));
    drain_answers();
    set_entry_count((1 << COUNT_W) - 1);
    repeat (10) lookup(pick_probe_key(TABLE_DEPTH));
    drain_answers();
    set_entry_count(TABLE_DEPTH + 1);
    repeat (10) lookup(pick_probe_key(TABLE_DEPTH));

    // every slot holds data from here on, so any count is safe to search
    beats = 0;
    while (beats < 1850) begin
      drain_answers();
      r = $urandom_range(0, 15);
      case (r)
        0: count = 0;
        1: count = TABLE_DEPTH;
        2: count = $urandom_range(TABLE_DEPTH + 1, (1 << COUNT_W) - 1);
        3: count = $urandom_range(41, 300);
        default: count = $urandom_range(1, 40);
      endcase
      set_entry_count(count);
      eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;

      if (count <= 300) begin
        mixed = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = '1 - 64'($urandom_range(0, 64));
          default: k = rand_key();
        endcase
        for (int unsigned i = 0; i < count; i++) begin
          if (mixed) begin
            // unsorted table, small values so some keys repeat
            k = $urandom_range(0, 1) ? rand_key() : 64'($urandom_range(0, 15));
          end else if (i != 0) begin
            case ($urandom_range(0, 7))
              0: inc = '0;
              1: inc = 64'd1;
              2, 3, 4: inc = 64'($urandom_range(2, 16));
              default: inc = {$urandom_range(0, 255), $urandom};
            endcase
            nk = k + inc;
            if (nk < k) nk = '1;
            k = nk;
          end
          img = ($urandom_range(0, 9) == 0) ? '1 : IDX_W'($urandom);
          send_beat(CMD_WRITE, SLOT_W'(i), k, img);
        end
      end

      repeat ($urandom_range(4, 30)) begin
        r = $urandom_range(0, 39);
        if (r == 0) begin
          drain_answers();
        end else if (r < 7 && eff < TABLE_DEPTH) begin
          // stray writes past the searched range
          send_beat(CMD_WRITE, SLOT_W'($urandom_range(eff, TABLE_DEPTH - 1)), rand_key(),
                    $urandom);
        end else begin
          lookup(pick_probe_key(eff));
        end
      end
    end

    drain_answers();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : answer_sink
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_stall_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      sb.check_answer(rsp_if.found, rsp_if.image_index);
      if ($urandom_range(0, 49) == 0) rx_stall_on = !rx_stall_on;
    end
  end

endmodule
